// File: hdl/sha1sh_pkg.sv
// shared types, constants and codes for the sha-1 stream hasher
`timescale 1ns / 1ps

package sha1sh_pkg;

    // item codes
    localparam logic MODE_ABSORB = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    localparam int BLOCK_BYTES = 64;
    localparam int NUM_ROUNDS  = 80;
    localparam int NUM_WORDS   = 5;

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_INDEX = 3'd4;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    // round group boundaries
    localparam logic [6:0] ROUND_G1 = 7'd20;
    localparam logic [6:0] ROUND_G2 = 7'd40;
    localparam logic [6:0] ROUND_G3 = 7'd60;

    localparam logic [31:0] IV_0 = 32'h67452301;
    localparam logic [31:0] IV_1 = 32'hEFCDAB89;
    localparam logic [31:0] IV_2 = 32'h98BADCFE;
    localparam logic [31:0] IV_3 = 32'h10325476;
    localparam logic [31:0] IV_4 = 32'hC3D2E1F0;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    typedef logic [4:0][31:0] chain_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       start;
        logic       do_round;
        logic [6:0] round_idx;
        logic       fold;
        logic       iv;
    } ctrl_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } msg_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_t;

endpackage

// File: hdl/sha1sh_sched.sv
// message window: byte loading and the 16-word sha-1 schedule recurrence
`timescale 1ns / 1ps

module sha1sh_sched (
    input  logic                clk,
    input  sha1sh_pkg::ctrl_t   ctrl,
    output logic [31:0]         w_cur
);

    logic [511:0] window_reg;
    logic [511:0] window_next;
    logic [31:0]  mix;
    logic [31:0]  w_new;

    // window word i sits at [511-32*i -: 32]; word 0 is the current round word
    assign mix   = window_reg[95:64] ^ window_reg[255:224]
                 ^ window_reg[447:416] ^ window_reg[511:480];
    assign w_new = {mix[30:0], mix[31]};
    assign w_cur = window_reg[511:480];

    always_comb
    begin
        window_next = window_reg;
        if (ctrl.push)
        begin
            window_next = {window_reg[503:0], ctrl.push_byte};
        end
        else if (ctrl.do_round)
        begin
            window_next = {window_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

endmodule

// File: hdl/sha1sh_round.sv
// shared sha-1 round unit with working variables and chaining words
`timescale 1ns / 1ps

module sha1sh_round (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1sh_pkg::ctrl_t   ctrl,
    input  logic [31:0]         w_cur,
    output sha1sh_pkg::chain_t  chain
);

    sha1sh_pkg::chain_t chain_reg;
    sha1sh_pkg::chain_t chain_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;

    always_comb
    begin
        if (ctrl.round_idx < sha1sh_pkg::ROUND_G1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1sh_pkg::K_0;
        end
        else if (ctrl.round_idx < sha1sh_pkg::ROUND_G2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1sh_pkg::K_1;
        end
        else if (ctrl.round_idx < sha1sh_pkg::ROUND_G3)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1sh_pkg::K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1sh_pkg::K_3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        chain_next = chain_reg;
        if (ctrl.start)
        begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
            e_next = chain_reg[4];
        end
        else if (ctrl.do_round)
        begin
            a_next = t_val;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end
        if (ctrl.fold)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
        else if (ctrl.iv)
        begin
            chain_next = {sha1sh_pkg::IV_4, sha1sh_pkg::IV_3, sha1sh_pkg::IV_2,
                          sha1sh_pkg::IV_1, sha1sh_pkg::IV_0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= {sha1sh_pkg::IV_4, sha1sh_pkg::IV_3, sha1sh_pkg::IV_2,
                          sha1sh_pkg::IV_1, sha1sh_pkg::IV_0};
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

    assign chain = chain_reg;

endmodule

// File: hdl/sha1_stream_hasher.sv
// top level: byte-stream sha-1 hasher with padding sequencer and digest output
// blocks: a data byte is taken while idle; the byte that fills a block starts the
//   rounds on the shared round unit, then its working variables fold into the chaining words
// finish: pad and length bytes, one or two compressions, then five digest words,
//   one per accepted cycle; msg_ready stays low until the last
// reset: rst_n (async, active low) loads the initial vector and clears fill, bit
//   count and sequencer state; the message window needs no reset
`timescale 1ns / 1ps

module sha1_stream_hasher (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    output logic                   msg_ready,
    input  sha1sh_pkg::msg_t       msg,
    output logic                   digest_valid,
    input  logic                   digest_ready,
    output sha1sh_pkg::digest_t    digest
);

    sha1sh_pkg::state_t state_reg, state_next;
    sha1sh_pkg::ctrl_t  ctrl;
    sha1sh_pkg::chain_t chain;

    logic [5:0]  fill_reg, fill_next;       // bytes held in the current block
    logic [63:0] bitcnt_reg, bitcnt_next;   // message length in bits, wraps
    logic [6:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;         // digest word being handed out
    logic        fin_reg, fin_next;         // finish request in progress
    logic        first_reg, first_next;     // next pad byte is the 0x80 marker
    logic        len_reg, len_next;         // length bytes have started
    logic        do_push;
    logic [7:0]  push_val;
    logic [63:0] len_shift;
    logic [31:0] w_cur;
    logic [31:0] word_sel;

    // length bytes go out most significant first at block offsets 56..63
    assign len_shift = bitcnt_reg << {fill_reg[2:0], 3'b000};

    assign msg_ready    = (state_reg == sha1sh_pkg::ST_IDLE);
    assign digest_valid = (state_reg == sha1sh_pkg::ST_EMIT);

    always_comb
    begin
        unique case (idx_reg)
            3'd0:    word_sel = chain[0];
            3'd1:    word_sel = chain[1];
            3'd2:    word_sel = chain[2];
            3'd3:    word_sel = chain[3];
            default: word_sel = chain[4];
        endcase
    end

    assign digest.digest_word = word_sel;
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == sha1sh_pkg::LAST_INDEX);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bitcnt_next = bitcnt_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        fin_next    = fin_reg;
        first_next  = first_reg;
        len_next    = len_reg;
        do_push     = 1'b0;
        push_val    = 8'h00;
        ctrl        = '0;
        ctrl.round_idx = round_reg;

        unique case (state_reg)
            sha1sh_pkg::ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.mode == sha1sh_pkg::MODE_FINISH)
                    begin
                        fin_next   = 1'b1;
                        first_next = 1'b1;
                        state_next = sha1sh_pkg::ST_PAD;
                    end
                    else
                    begin
                        do_push     = 1'b1;
                        push_val    = msg.data_byte;
                        bitcnt_next = bitcnt_reg + 64'd8;
                    end
                end
            end
            sha1sh_pkg::ST_PAD:
            begin
                do_push = 1'b1;
                if (first_reg)
                begin
                    push_val   = sha1sh_pkg::PAD_BYTE;
                    first_next = 1'b0;
                end
                else if (len_reg || (fill_reg == sha1sh_pkg::LEN_POS))
                begin
                    push_val = len_shift[63:56];
                    len_next = 1'b1;
                end
            end
            sha1sh_pkg::ST_ROUND:
            begin
                ctrl.do_round = 1'b1;
                round_next    = round_reg + 7'd1;
                if (round_reg == sha1sh_pkg::LAST_ROUND)
                begin
                    state_next = sha1sh_pkg::ST_FOLD;
                end
            end
            sha1sh_pkg::ST_FOLD:
            begin
                ctrl.fold = 1'b1;
                if (fin_reg && len_reg)
                begin
                    state_next = sha1sh_pkg::ST_EMIT;
                end
                else if (fin_reg)
                begin
                    state_next = sha1sh_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha1sh_pkg::ST_IDLE;
                end
            end
            sha1sh_pkg::ST_EMIT:
            begin
                if (digest_ready)
                begin
                    if (idx_reg == sha1sh_pkg::LAST_INDEX)
                    begin
                        // back to a fresh message
                        ctrl.iv     = 1'b1;
                        idx_next    = 3'd0;
                        bitcnt_next = 64'd0;
                        fin_next    = 1'b0;
                        len_next    = 1'b0;
                        state_next  = sha1sh_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = sha1sh_pkg::ST_IDLE;
            end
        endcase

        // byte push shared by data and padding; a full block starts the rounds
        if (do_push)
        begin
            ctrl.push      = 1'b1;
            ctrl.push_byte = push_val;
            if (fill_reg == sha1sh_pkg::FILL_LAST)
            begin
                fill_next  = 6'd0;
                ctrl.start = 1'b1;
                round_next = 7'd0;
                state_next = sha1sh_pkg::ST_ROUND;
            end
            else
            begin
                fill_next = fill_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha1sh_pkg::ST_IDLE;
            fill_reg   <= 6'd0;
            bitcnt_reg <= 64'd0;
            round_reg  <= 7'd0;
            idx_reg    <= 3'd0;
            fin_reg    <= 1'b0;
            first_reg  <= 1'b0;
            len_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bitcnt_reg <= bitcnt_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            fin_reg    <= fin_next;
            first_reg  <= first_next;
            len_reg    <= len_next;
        end
    end

    sha1sh_sched u_sched (
        .clk   (clk),
        .ctrl  (ctrl),
        .w_cur (w_cur)
    );

    sha1sh_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .w_cur (w_cur),
        .chain (chain)
    );

    // digest only goes out once the final block has been folded
    a_emit_empty_block: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (fill_reg == 6'd0) && fin_reg && len_reg)
        else $error("digest handed out with a partial block");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1sh_pkg::ST_ROUND) |-> (round_reg <= sha1sh_pkg::LAST_ROUND))
        else $error("round counter overran");

    a_last_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && digest.last_word |=> msg_ready && (bitcnt_reg == 64'd0))
        else $error("hasher not reset after final digest word");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (idx_reg <= sha1sh_pkg::LAST_INDEX))
        else $error("digest word index out of range");

    a_full_block_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push && (fill_reg == sha1sh_pkg::FILL_LAST) |=>
            (state_reg == sha1sh_pkg::ST_ROUND) && (round_reg == 7'd0))
        else $error("full block did not start compression");

endmodule
